FILE: rtl/rqu_pkg.sv
// Shared types, constants and helper functions for the rotation vector to quaternion unit.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none
package rqu_pkg;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic [31:0]        theta;
        logic signed [31:0] z;
        logic               flip;
        logic               ident;
    } t_entry;

    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [33:0] Q30_MONE    = -34'sd1073741824;
    localparam logic [15:0]        LIMIT_RESET = 16'd1;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat_q30(input logic signed [33:0] v);
        logic signed [33:0] s;
        if (v > Q30_ONE) begin
            s = Q30_ONE;
        end else if (v < Q30_MONE) begin
            s = Q30_MONE;
        end else begin
            s = v;
        end
        return s[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rqu_ifs.sv
// Channel interfaces of the rotation vector to quaternion unit: input, result and config.
// No dependencies.
`default_nettype none
interface rqu_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
    modport sink (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

interface rqu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               is_identity;
    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, output is_identity, input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, input is_identity, output ready);
endinterface

interface rqu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rqu_front.sv
// Front end: squares, 64-bit integer square root pipeline, small angle test and angle reduction.
// Depends on rqu_pkg and rqu_in_if.
`default_nettype none
module rqu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    rqu_in_if.sink            i_in,
    input  wire logic [15:0]  i_limit,
    input  wire logic         i_push_ready,
    output logic              o_push_valid,
    output rqu_pkg::t_entry   o_push_data
);
    localparam int SqSteps = 32;

    logic                en;
    logic                r_a_valid;
    logic [95:0]         r_a_vec;
    logic [63:0]         r_a_sq [0:2];
    logic [SqSteps:0]    r_sv;
    logic [63:0]         r_rem [0:SqSteps];
    logic [63:0]         r_res [0:SqSteps];
    logic [95:0]         r_vec [0:SqSteps];
    logic                r_c_valid;
    rqu_pkg::t_entry     r_c_data;
    rqu_pkg::t_entry     n_c_data;
    logic signed [63:0]  sq_x, sq_y, sq_z;
    logic [31:0]         theta;
    logic signed [35:0]  z0, z1, z2;

    function automatic logic [127:0] sq_step(input logic [63:0] rem, input logic [63:0] res,
                                             input int k);
        logic [63:0] bitv;
        logic [63:0] rb;
        bitv = 64'd1 << (62 - 2 * k);
        rb   = res + bitv;
        if (rem >= rb) begin
            return {rem - rb, (res >> 1) + bitv};
        end
        return {rem, res >> 1};
    endfunction

    assign en         = !r_c_valid || i_push_ready;
    assign i_in.ready = en;
    assign sq_x = i_in.rot_x * i_in.rot_x;
    assign sq_y = i_in.rot_y * i_in.rot_y;
    assign sq_z = i_in.rot_z * i_in.rot_z;

    always_comb begin
        theta = r_res[SqSteps][31:0];
        z0 = $signed({3'b000, theta, 1'b0});
        z1 = (z0 > rqu_pkg::Q30_PI) ? z0 - rqu_pkg::Q30_TWO_PI : z0;
        n_c_data.flip = 1'b0;
        z2 = z1;
        if (z1 > rqu_pkg::Q30_HALF_PI) begin
            z2 = z1 - rqu_pkg::Q30_PI;
            n_c_data.flip = 1'b1;
        end else if (z1 < -rqu_pkg::Q30_HALF_PI) begin
            z2 = z1 + rqu_pkg::Q30_PI;
            n_c_data.flip = 1'b1;
        end
        n_c_data.rx    = r_vec[SqSteps][95:64];
        n_c_data.ry    = r_vec[SqSteps][63:32];
        n_c_data.rz    = r_vec[SqSteps][31:0];
        n_c_data.theta = theta;
        n_c_data.z     = z2[31:0];
        n_c_data.ident = (theta == 32'd0) || (theta < {16'd0, i_limit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_sv      <= '0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
            r_sv      <= {r_sv[SqSteps-1:0], r_a_valid};
            r_c_valid <= r_sv[SqSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_vec  <= {i_in.rot_x, i_in.rot_y, i_in.rot_z};
            r_a_sq[0] <= sq_x;
            r_a_sq[1] <= sq_y;
            r_a_sq[2] <= sq_z;
            r_rem[0] <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_res[0] <= 64'd0;
            r_vec[0] <= r_a_vec;
            for (int k = 0; k < SqSteps; k++) begin
                {r_rem[k+1], r_res[k+1]} <= sq_step(r_rem[k], r_res[k], k);
                r_vec[k+1] <= r_vec[k];
            end
            r_c_data <= n_c_data;
        end
    end

    assign o_push_valid = r_c_valid;
    assign o_push_data  = r_c_data;
endmodule
`default_nettype wire

FILE: rtl/rqu_queue.sv
// Short FIFO of classified words between the front end and the back end.
// Depends on rqu_pkg.
`default_nettype none
module rqu_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    input  wire rqu_pkg::t_entry i_push_data,
    output logic                 o_push_ready,
    input  wire logic            i_pop,
    output logic                 o_head_valid,
    output rqu_pkg::t_entry      o_head_data
);
    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    rqu_pkg::t_entry   r_mem [0:Depth-1];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [PtrW:0]     r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != Depth[PtrW:0]);
    assign o_head_valid = (r_cnt != '0);
    assign o_head_data  = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rqu_back.sv
// Back end: CORDIC sine and cosine pipeline, scaling multiply, three pipelined dividers,
// saturation and the result register. Depends on rqu_pkg and rqu_out_if.
`default_nettype none
module rqu_back #(
    parameter int Steps = 24
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_head_valid,
    input  wire rqu_pkg::t_entry i_head_data,
    output logic                 o_pop,
    rqu_out_if.source            o_out
);
    localparam int DivSteps = 32;

    logic                en;
    logic [Steps:0]      r_cv;
    logic signed [33:0]  r_x [0:Steps];
    logic signed [33:0]  r_y [0:Steps];
    logic signed [33:0]  r_z [0:Steps];
    rqu_pkg::t_entry     r_e [0:Steps];

    logic                r_mv;
    logic signed [65:0]  r_mp [0:2];
    logic signed [33:0]  r_mcs;
    logic [31:0]         r_mtheta;
    logic                r_mident;

    logic [DivSteps:0]   r_dv;
    logic [31:0]         r_drem [0:DivSteps][0:2];
    logic [31:0]         r_dlo  [0:DivSteps][0:2];
    logic [31:0]         r_dq   [0:DivSteps][0:2];
    logic [2:0]          r_dneg [0:DivSteps];
    logic signed [33:0]  r_dcs  [0:DivSteps];
    logic [31:0]         r_dtheta [0:DivSteps];
    logic                r_dident [0:DivSteps];

    logic                r_o_valid;
    logic signed [31:0]  r_o_w, r_o_x, r_o_y, r_o_z;
    logic                r_o_ident;

    logic signed [33:0]  sn, cs;
    logic signed [31:0]  rv [0:2];
    logic signed [65:0]  mag [0:2];
    logic signed [33:0]  qs [0:2];

    assign en    = !r_o_valid || o_out.ready;
    assign o_pop = en;

    always_comb begin
        sn = r_e[Steps].flip ? -r_y[Steps] : r_y[Steps];
        cs = r_e[Steps].flip ? -r_x[Steps] : r_x[Steps];
        rv[0] = r_e[Steps].rx;
        rv[1] = r_e[Steps].ry;
        rv[2] = r_e[Steps].rz;
        for (int j = 0; j < 3; j++) begin
            mag[j] = r_mp[j][65] ? -r_mp[j] : r_mp[j];
            qs[j]  = r_dneg[DivSteps][j] ? -$signed({2'b00, r_dq[DivSteps][j]})
                                         : $signed({2'b00, r_dq[DivSteps][j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv      <= '0;
            r_mv      <= 1'b0;
            r_dv      <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_cv      <= {r_cv[Steps-1:0], i_head_valid};
            r_mv      <= r_cv[Steps];
            r_dv      <= {r_dv[DivSteps-1:0], r_mv};
            r_o_valid <= r_dv[DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0] <= rqu_pkg::GAIN_INV;
            r_y[0] <= 34'sd0;
            r_z[0] <= 34'(i_head_data.z);
            r_e[0] <= i_head_data;
            for (int i = 0; i < Steps; i++) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - rqu_pkg::atan_q30(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + rqu_pkg::atan_q30(5'(i));
                end
                r_e[i+1] <= r_e[i];
            end

            for (int j = 0; j < 3; j++) begin
                r_mp[j] <= sn * rv[j];
            end
            r_mcs    <= cs;
            r_mtheta <= r_e[Steps].theta;
            r_mident <= r_e[Steps].ident;

            for (int j = 0; j < 3; j++) begin
                r_drem[0][j] <= mag[j][63:32];
                r_dlo[0][j]  <= mag[j][31:0];
                r_dq[0][j]   <= 32'd0;
                r_dneg[0][j] <= r_mp[j][65];
            end
            r_dcs[0]    <= r_mcs;
            r_dtheta[0] <= r_mtheta;
            r_dident[0] <= r_mident;
            for (int d = 0; d < DivSteps; d++) begin
                for (int j = 0; j < 3; j++) begin
                    if ({r_drem[d][j], r_dlo[d][j][31]} >= {1'b0, r_dtheta[d]}) begin
                        r_drem[d+1][j] <= 32'({r_drem[d][j], r_dlo[d][j][31]}
                                              - {1'b0, r_dtheta[d]});
                        r_dq[d+1][j]   <= {r_dq[d][j][30:0], 1'b1};
                    end else begin
                        r_drem[d+1][j] <= {r_drem[d][j][30:0], r_dlo[d][j][31]};
                        r_dq[d+1][j]   <= {r_dq[d][j][30:0], 1'b0};
                    end
                    r_dlo[d+1][j] <= {r_dlo[d][j][30:0], 1'b0};
                end
                r_dneg[d+1]   <= r_dneg[d];
                r_dcs[d+1]    <= r_dcs[d];
                r_dtheta[d+1] <= r_dtheta[d];
                r_dident[d+1] <= r_dident[d];
            end

            r_o_ident <= r_dident[DivSteps];
            if (r_dident[DivSteps]) begin
                r_o_w <= rqu_pkg::Q30_ONE[31:0];
                r_o_x <= 32'sd0;
                r_o_y <= 32'sd0;
                r_o_z <= 32'sd0;
            end else begin
                r_o_w <= rqu_pkg::sat_q30(r_dcs[DivSteps]);
                r_o_x <= rqu_pkg::sat_q30(qs[0]);
                r_o_y <= rqu_pkg::sat_q30(qs[1]);
                r_o_z <= rqu_pkg::sat_q30(qs[2]);
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.quat_w      = r_o_w;
    assign o_out.quat_x      = r_o_x;
    assign o_out.quat_y      = r_o_y;
    assign o_out.quat_z      = r_o_z;
    assign o_out.is_identity = r_o_ident;

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dv) && $stable(r_cv) && $stable(r_mv))
        else $error("back pipeline moved while the result word was stalled");
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv && en |=> r_dv[0])
        else $error("multiply stage word lost on its way into the divider");
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_w <= 32'sd1073741824) && (o_out.quat_w >= -32'sd1073741824))
        else $error("scalar part outside the saturation bounds");
    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_identity |-> (o_out.quat_x == 32'sd0)
            && (o_out.quat_y == 32'sd0) && (o_out.quat_z == 32'sd0))
        else $error("identity word carries a nonzero vector part");
endmodule
`default_nettype wire

FILE: rtl/rotvec_to_quaternion_unit.sv
// Top level of the rotation vector to quaternion unit: config register, front end, queue
// and back end. Depends on rqu_pkg, rqu_ifs, rqu_front, rqu_queue and rqu_back.
//
// Usage: each word on i_in carries a rotation vector (three signed Q3.28 components).
// Exactly one result word on o_out follows for every input word, in order, holding the
// quaternion in signed Q1.30 and the identity flag. i_cfg writes the 16-bit small angle
// limit; it is always ready and should be written only while the unit is empty.
// Throughput is one word per cycle while o_out.ready is not held low. The front end finds
// the norm with a square root pipeline of one result bit per stage, the back end runs one
// CORDIC step per stage and three dividers of one quotient bit per stage.
// A four-word queue between the two halves lets the front end keep accepting while the
// back end is stalled. When the receiver holds o_out.ready low the result word stays put,
// the back end freezes, and i_in.ready drops once the queue is full and a word waits at
// the end of the front end.
// Synchronous active-low reset empties all pipelines and the queue and sets the limit to 1.
`default_nettype none
module rotvec_to_quaternion_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rqu_in_if.sink    i_in,
    rqu_cfg_if.sink   i_cfg,
    rqu_out_if.source o_out
);
    logic [15:0]     r_limit;
    logic            push_valid;
    logic            push_ready;
    rqu_pkg::t_entry push_data;
    logic            head_valid;
    rqu_pkg::t_entry head_data;
    logic            pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rqu_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    rqu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_limit      (r_limit),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data)
    );

    rqu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_data  (head_data)
    );

    rqu_back #(
        .Steps (CORDIC_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_data  (head_data),
        .o_pop        (pop),
        .o_out        (o_out)
    );
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for rotvec_to_quaternion_unit: drives rotation vectors and limit writes,
// predicts each quaternion word in a scoreboard class and compares each result word with it.
// Depends on rqu_pkg, rqu_ifs and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ident;
    } t_quat;

    class quat_scoreboard;
        t_quat        pending[$];
        logic [15:0]  angle_limit;
        int           n_mismatch;

        function new();
            angle_limit = rqu_pkg::LIMIT_RESET;
            n_mismatch  = 0;
        endfunction

        function automatic longint shr_floor(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint clamp_q30(longint v);
            if (v > 64'sd1073741824) return 64'sd1073741824;
            if (v < -64'sd1073741824) return -64'sd1073741824;
            return v;
        endfunction

        function automatic longint unsigned norm_floor(longint unsigned v);
            longint unsigned rem, res, b;
            rem = v;
            res = 0;
            b = 64'd1 << 62;
            while (b > rem) b >>= 2;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note_vector(logic signed [31:0] rx, logic signed [31:0] ry,
                                  logic signed [31:0] rz);
            longint r[3];
            longint unsigned sq;
            longint unsigned theta;
            longint ang, cx, cy, dx, dy, sn, cs;
            bit flip;
            t_quat q;
            longint tbl[32];
            tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                    128, 64, 32, 16, 8, 4, 2, 1, 0};
            r[0] = rx;
            r[1] = ry;
            r[2] = rz;
            sq = 0;
            for (int i = 0; i < 3; i++) sq += longint'(r[i] * r[i]);
            theta = norm_floor(sq);
            if (theta == 0 || theta < angle_limit) begin
                q = '{32'sd1073741824, 0, 0, 0, 1'b1};
                pending = {pending, q};
                return;
            end
            flip = 0;
            ang = longint'(theta) * 2;
            if (ang > 64'sd3373259426) ang -= 64'sd6746518852;
            if (ang > 64'sd1686629713) begin
                ang -= 64'sd3373259426;
                flip = 1;
            end else if (ang < -64'sd1686629713) begin
                ang += 64'sd3373259426;
                flip = 1;
            end
            cx = 652032874;
            cy = 0;
            for (int i = 0; i < 24; i++) begin
                dx = shr_floor(cy, i);
                dy = shr_floor(cx, i);
                if (ang >= 0) begin
                    cx -= dx;
                    cy += dy;
                    ang -= tbl[i];
                end else begin
                    cx += dx;
                    cy -= dy;
                    ang += tbl[i];
                end
            end
            cs = flip ? -cx : cx;
            sn = flip ? -cy : cy;
            q.w = 32'(clamp_q30(cs));
            q.x = 32'(clamp_q30((sn * r[0]) / longint'(theta)));
            q.y = 32'(clamp_q30((sn * r[1]) / longint'(theta)));
            q.z = 32'(clamp_q30((sn * r[2]) / longint'(theta)));
            q.ident = 1'b0;
            pending = {pending, q};
        endfunction

        function void check_quat(t_quat got);
            t_quat e;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result word w=%0d", got.w);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: exp %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                             e.w, e.x, e.y, e.z, e.ident, got.w, got.x, got.y, got.z,
                             got.ident);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    quat_scoreboard quat_sb;

    rqu_in_if  vec_ch();
    rqu_cfg_if cfg_ch();
    rqu_out_if quat_ch();

    rotvec_to_quaternion_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vec_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (quat_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #50ms;
        $display("tb_top NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && quat_ch.valid && quat_ch.ready)
            quat_sb.check_quat('{quat_ch.quat_w, quat_ch.quat_x, quat_ch.quat_y,
                                 quat_ch.quat_z, quat_ch.is_identity});
        if (i_rst_n && vec_ch.valid && vec_ch.ready)
            quat_sb.note_vector(vec_ch.rot_x, vec_ch.rot_y, vec_ch.rot_z);
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready)
            quat_sb.angle_limit = cfg_ch.data;
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            quat_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            quat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_vector(logic signed [31:0] rx, logic signed [31:0] ry,
                               logic signed [31:0] rz);
        while ($urandom_range(99) < send_idle_pct) begin
            vec_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.rot_x <= rx;
        vec_ch.rot_y <= ry;
        vec_ch.rot_z <= rz;
        @(posedge i_clk);
        while (!vec_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        vec_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        vec_ch.valid <= 1'b0;
        n = 0;
        while (quat_sb.pending.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_comp(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(131071)) - 65536;
            2: return $signed($urandom_range(1 << 28)) - (1 << 27);
            default: return $signed($urandom_range(1 << 30)) - (1 << 29);
        endcase
    endfunction

    task automatic random_phase(int n);
        int m;
        for (int k = 0; k < n; k++) begin
            m = $urandom_range(3);
            send_vector(rand_comp(m), rand_comp(m), rand_comp(m));
        end
    endtask

    initial begin
        quat_sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 0;
        i_rst_n        = 1'b0;
        vec_ch.valid   = 1'b0;
        vec_ch.rot_x   = '0;
        vec_ch.rot_y   = '0;
        vec_ch.rot_z   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_vector(0, 0, 0);
        send_vector(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_vector(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_vector(32'sh80000000, 0, 0);
        send_vector(0, 32'sh7fffffff, 0);
        send_vector(0, 0, -1);
        send_vector(1, 0, 0);
        send_vector(32'sd421657428, 0, 0);
        send_vector(-32'sd843314856, 0, 0);
        send_vector(32'sd843314857, 0, 0);
        send_vector(0, 32'sd1686629713, 0);
        send_vector(0, 0, 32'sd1686629714);
        send_vector(32'sd268435456, -32'sd268435456, 32'sd268435456);
        send_vector(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
        drain();
        write_limit(16'd0);
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        drain();
        write_limit(16'hffff);
        send_vector(16'hfffe, 0, 0);
        send_vector(0, 16'hffff, 0);
        send_vector(-32'sd40000, -32'sd40000, 0);
        random_phase(100);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_limit(ph == 3 ? 16'd0 : 16'($urandom_range(65535)));
            send_idle_pct  = (ph == 1) ? 62 : (ph == 3 ? 38 : 0);
            recv_stall_pct = (ph == 2) ? 62 : (ph == 3 ? 38 : 0);
            if (ph == 0) hold_off <= 300;
            random_phase(320);
            drain();
        end

        if (quat_sb.n_mismatch == 0 && quat_sb.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
